/* src/hvrf_pkg.sv */
// Shared constants for the HSV value-substitution fusion pipeline.
package hvrf_pkg;

   localparam int unsigned NUM_CH = 3;

   localparam int unsigned CH_RED   = 0;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_BLUE  = 2;

endpackage

/* src/hvrf_if.sv */
// Valid/ready channel interfaces for pixel requests and fused responses.
interface hvrf_req_if #(
   parameter int unsigned PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] red_in;
   logic [PIXEL_BITS-1:0] green_in;
   logic [PIXEL_BITS-1:0] blue_in;
   logic [PIXEL_BITS-1:0] gray_in;

   modport source (output valid, red_in, green_in, blue_in, gray_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, gray_in, output ready);
endinterface

interface hvrf_rsp_if #(
   parameter int unsigned PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] red_out;
   logic [PIXEL_BITS-1:0] green_out;
   logic [PIXEL_BITS-1:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

/* src/hvrf_prep.sv */
// Front stage: peak channel search and channel-by-gray products.
module hvrf_prep
   import hvrf_pkg::*;
#(
   parameter int unsigned PIXEL_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  valid_in,
   input  logic [PIXEL_BITS-1:0]                 red,
   input  logic [PIXEL_BITS-1:0]                 green,
   input  logic [PIXEL_BITS-1:0]                 blue,
   input  logic [PIXEL_BITS-1:0]                 gray,
   output logic                                  valid_ff,
   output logic [PIXEL_BITS-1:0]                 peak_ff,
   output logic [PIXEL_BITS-1:0]                 gray_ff,
   output logic                                  zero_ff,
   output logic [NUM_CH-1:0][PIXEL_BITS-1:0]     rem_ff,
   output logic [NUM_CH-1:0][PIXEL_BITS-1:0]     quo_ff
);

   logic [NUM_CH-1:0][PIXEL_BITS-1:0]   chan;
   logic [PIXEL_BITS-1:0]               peak_rg;
   logic [PIXEL_BITS-1:0]               peak_in;
   logic [NUM_CH-1:0][2*PIXEL_BITS-1:0] prod;

   always_comb begin
      chan[CH_RED]   = red;
      chan[CH_GREEN] = green;
      chan[CH_BLUE]  = blue;
      peak_rg = (green > red) ? green : red;
      peak_in = (blue > peak_rg) ? blue : peak_rg;
      for (int c = 0; c < NUM_CH; c++) begin
         prod[c] = (2*PIXEL_BITS)'(chan[c]) * (2*PIXEL_BITS)'(gray);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         peak_ff <= peak_in;
         gray_ff <= gray;
         zero_ff <= (peak_in == '0);
         for (int c = 0; c < NUM_CH; c++) begin
            rem_ff[c] <= prod[c][2*PIXEL_BITS-1:PIXEL_BITS];
            quo_ff[c] <= prod[c][PIXEL_BITS-1:0];
         end
      end
   end

endmodule

/* src/hvrf_div_step.sv */
// One restoring-division step: one quotient bit per channel.
module hvrf_div_step
   import hvrf_pkg::*;
#(
   parameter int unsigned PIXEL_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  valid_in,
   input  logic [PIXEL_BITS-1:0]                 peak_in,
   input  logic [PIXEL_BITS-1:0]                 gray_in,
   input  logic                                  zero_in,
   input  logic [NUM_CH-1:0][PIXEL_BITS-1:0]     rem_in,
   input  logic [NUM_CH-1:0][PIXEL_BITS-1:0]     quo_in,
   output logic                                  valid_ff,
   output logic [PIXEL_BITS-1:0]                 peak_ff,
   output logic [PIXEL_BITS-1:0]                 gray_ff,
   output logic                                  zero_ff,
   output logic [NUM_CH-1:0][PIXEL_BITS-1:0]     rem_ff,
   output logic [NUM_CH-1:0][PIXEL_BITS-1:0]     quo_ff
);

   logic [NUM_CH-1:0][PIXEL_BITS:0]   trial;
   logic [NUM_CH-1:0][PIXEL_BITS:0]   diff;
   logic [NUM_CH-1:0]                 fits;
   logic [NUM_CH-1:0][PIXEL_BITS-1:0] rem_nx;
   logic [NUM_CH-1:0][PIXEL_BITS-1:0] quo_nx;

   // remainder stays below peak, so both arms fit PIXEL_BITS
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         trial[c]  = {rem_in[c], quo_in[c][PIXEL_BITS-1]};
         diff[c]   = trial[c] - {1'b0, peak_in};
         fits[c]   = (trial[c] >= {1'b0, peak_in});
         rem_nx[c] = fits[c] ? diff[c][PIXEL_BITS-1:0] : trial[c][PIXEL_BITS-1:0];
         quo_nx[c] = {quo_in[c][PIXEL_BITS-2:0], fits[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         peak_ff <= peak_in;
         gray_ff <= gray_in;
         zero_ff <= zero_in;
         rem_ff  <= rem_nx;
         quo_ff  <= quo_nx;
      end
   end

endmodule

/* src/hsv_value_replace_fusion_core.sv */
// HSV value-substitution fusion: out = floor(c * gray / max(r, g, b)) per channel.
// Takes one pixel per clock cycle unless the response side stalls, and returns
// its fused colour through a pipeline: one stage forms the peak channel and the
// three channel-by-gray products, then PIXEL_BITS stages of a restoring divider
// each settle one quotient bit for all three channels. A black pixel (peak zero)
// returns gray on every channel. When the response side stalls the whole
// pipeline holds, and req.ready drops until the held result is taken.
module hsv_value_replace_fusion_core
   import hvrf_pkg::*;
#(
   parameter int unsigned PIXEL_BITS = 8
) (
   input  logic      clock,
   input  logic      reset,
   hvrf_req_if.sink  req,
   hvrf_rsp_if.source rsp
);

   localparam int unsigned N = PIXEL_BITS + 1;

   logic                                      en;
   logic [N-1:0]                              st_valid;
   logic [N-1:0][PIXEL_BITS-1:0]              st_peak;
   logic [N-1:0][PIXEL_BITS-1:0]              st_gray;
   logic [N-1:0]                              st_zero;
   logic [N-1:0][NUM_CH-1:0][PIXEL_BITS-1:0]  st_rem;
   logic [N-1:0][NUM_CH-1:0][PIXEL_BITS-1:0]  st_quo;

   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;

   hvrf_prep #(
      .PIXEL_BITS(PIXEL_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .valid_in (req.valid),
      .red      (req.red_in),
      .green    (req.green_in),
      .blue     (req.blue_in),
      .gray     (req.gray_in),
      .valid_ff (st_valid[0]),
      .peak_ff  (st_peak[0]),
      .gray_ff  (st_gray[0]),
      .zero_ff  (st_zero[0]),
      .rem_ff   (st_rem[0]),
      .quo_ff   (st_quo[0])
   );

   for (genvar i = 0; i < PIXEL_BITS; i++) begin : g_div
      hvrf_div_step #(
         .PIXEL_BITS(PIXEL_BITS)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .valid_in (st_valid[i]),
         .peak_in  (st_peak[i]),
         .gray_in  (st_gray[i]),
         .zero_in  (st_zero[i]),
         .rem_in   (st_rem[i]),
         .quo_in   (st_quo[i]),
         .valid_ff (st_valid[i+1]),
         .peak_ff  (st_peak[i+1]),
         .gray_ff  (st_gray[i+1]),
         .zero_ff  (st_zero[i+1]),
         .rem_ff   (st_rem[i+1]),
         .quo_ff   (st_quo[i+1])
      );
   end

   assign rsp.valid     = st_valid[N-1];
   assign rsp.red_out   = st_zero[N-1] ? st_gray[N-1] : st_quo[N-1][CH_RED];
   assign rsp.green_out = st_zero[N-1] ? st_gray[N-1] : st_quo[N-1][CH_GREEN];
   assign rsp.blue_out  = st_zero[N-1] ? st_gray[N-1] : st_quo[N-1][CH_BLUE];

`ifndef SYNTHESIS
   // the peak channel always scales to exactly gray
   a_peak_hits_gray: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.red_out == st_gray[N-1]) || (rsp.green_out == st_gray[N-1])
                    || (rsp.blue_out == st_gray[N-1]))
      else $error("no channel equals gray");

   a_never_above_gray: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.red_out <= st_gray[N-1]) && (rsp.green_out <= st_gray[N-1])
                    && (rsp.blue_out <= st_gray[N-1]))
      else $error("channel above gray");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(st_valid))
      else $error("pipeline moved during stall");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      st_valid[0] |-> (st_zero[0] == (st_peak[0] == '0)))
      else $error("black-pixel flag mismatch");
`endif

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the HSV value-substitution fusion core.
module testbench
   import hvrf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PIXEL_BITS  = 8;
   localparam int unsigned LATENCY     = PIXEL_BITS + 1;
   localparam int unsigned DRAIN_WAIT  = 4 * LATENCY;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned IDLE_PCT    = 7;

   typedef logic [PIXEL_BITS-1:0] chan_t;

   typedef struct packed {
      chan_t red;
      chan_t green;
      chan_t blue;
      chan_t gray;
   } pixel_t;

   typedef struct packed {
      chan_t red;
      chan_t green;
      chan_t blue;
   } colour_t;

   logic clock = 1'b0;
   logic reset;

   hvrf_req_if #(.PIXEL_BITS(PIXEL_BITS)) req_bus ();
   hvrf_rsp_if #(.PIXEL_BITS(PIXEL_BITS)) rsp_bus ();

   hsv_value_replace_fusion_core #(.PIXEL_BITS(PIXEL_BITS)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source)
   );

   colour_t     expected_colours[$];
   colour_t     due;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left   = 0;
   bit          sender_gaps = 1'b1;
   bit          sink_stalls = 1'b1;

   always #6 clock = ~clock;

   function automatic colour_t fuse_pixel(pixel_t px);
      chan_t               chan [NUM_CH];
      chan_t               scaled [NUM_CH];
      chan_t               peak;
      logic [2*PIXEL_BITS-1:0] product;
      colour_t             res;
      chan[CH_RED]   = px.red;
      chan[CH_GREEN] = px.green;
      chan[CH_BLUE]  = px.blue;
      peak = '0;
      for (int i = 0; i < NUM_CH; i++)
         if (chan[i] > peak) peak = chan[i];
      for (int i = 0; i < NUM_CH; i++) begin
         if (peak == '0) begin
            scaled[i] = px.gray;
         end else begin
            product   = chan[i] * px.gray;
            scaled[i] = PIXEL_BITS'(product / peak);
         end
      end
      res.red   = scaled[CH_RED];
      res.green = scaled[CH_GREEN];
      res.blue  = scaled[CH_BLUE];
      return res;
   endfunction

   function automatic pixel_t random_pixel();
      pixel_t px;
      chan_t  level;
      px = pixel_t'($urandom);
      case ($urandom_range(9))
         0: begin
            px.red   = chan_t'($urandom_range(3));
            px.green = chan_t'($urandom_range(3));
            px.blue  = chan_t'($urandom_range(3));
         end
         1: begin
            level    = chan_t'($urandom);
            px.red   = level;
            px.green = level;
            px.blue  = level;
         end
         2: begin
            case ($urandom_range(2))
               0: px.red   = '1;
               1: px.green = '1;
               default: px.blue = '1;
            endcase
         end
         3: px.gray = $urandom_range(1) ? '1 : '0;
         4: begin
            case ($urandom_range(2))
               0: px.red   = '0;
               1: px.green = '0;
               default: px.blue = '0;
            endcase
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Called at a falling edge, returns at a falling edge with the transaction taken.
   task automatic send_pixel(pixel_t px);
      while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.red_in   <= px.red;
      req_bus.green_in <= px.green;
      req_bus.blue_in  <= px.blue;
      req_bus.gray_in  <= px.gray;
      do @(posedge clock); while (!req_bus.ready);
      expected_colours.push_back(fuse_pixel(px));
      @(negedge clock);
   endtask

   task automatic send_random(int unsigned count);
      repeat (count) send_pixel(random_pixel());
   endtask

   task automatic test_directed();
      pixel_t cases [$];
      cases = '{
         '{8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00, 8'hFF},
         '{8'h00, 8'h00, 8'h00, 8'h5A}, '{8'h01, 8'h01, 8'h01, 8'hFF},
         '{8'hFF, 8'hFF, 8'hFF, 8'h00}, '{8'hFF, 8'hFF, 8'hFF, 8'hFF},
         '{8'h80, 8'h80, 8'h80, 8'h37}, '{8'hFF, 8'h00, 8'h00, 8'hC8},
         '{8'h00, 8'hFF, 8'h00, 8'hC8}, '{8'h00, 8'h00, 8'hFF, 8'hC8},
         '{8'h01, 8'h00, 8'h00, 8'hFF}, '{8'h00, 8'h01, 8'h01, 8'hFF},
         '{8'hFF, 8'hFE, 8'h01, 8'hFE}, '{8'hFE, 8'h7F, 8'h01, 8'h01},
         '{8'h80, 8'h40, 8'h20, 8'hFF}, '{8'h55, 8'hAA, 8'h33, 8'hAA},
         '{8'hAA, 8'h55, 8'hCC, 8'h55}, '{8'h03, 8'h02, 8'h01, 8'hFF},
         '{8'h07, 8'hFF, 8'h80, 8'h01}, '{8'hFF, 8'hFF, 8'h00, 8'h7F}
      };
      foreach (cases[i]) send_pixel(cases[i]);
   endtask

   task automatic test_random_idling();
      sender_gaps = 1'b1;
      sink_stalls = 1'b1;
      send_random(400);
   endtask

   task automatic test_back_to_back();
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      send_random(200);
      sender_gaps = 1'b1;
      sink_stalls = 1'b1;
   endtask

   // Sink holds off long enough for the pipeline to fill and push back on the input.
   task automatic test_backpressure();
      sender_gaps = 1'b0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      hold_left = 300;
      @(negedge clock);
      send_random(100);
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_tail();
      send_random(200);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= !(sink_stalls && $urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_colours.size() == 0) begin
            report_mismatch("unexpected response, red", rsp_bus.red_out, 0);
         end else begin
            due = expected_colours.pop_front();
            if (rsp_bus.red_out !== due.red)
               report_mismatch("red_out", rsp_bus.red_out, due.red);
            if (rsp_bus.green_out !== due.green)
               report_mismatch("green_out", rsp_bus.green_out, due.green);
            if (rsp_bus.blue_out !== due.blue)
               report_mismatch("blue_out", rsp_bus.blue_out, due.blue);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.red_in   = '0;
      req_bus.green_in = '0;
      req_bus.blue_in  = '0;
      req_bus.gray_in  = '0;
      rsp_bus.ready    = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_idling();
      test_back_to_back();
      test_backpressure();
      test_random_tail();

      req_bus.valid <= 1'b0;
      while (expected_colours.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_colours.size() != 0)
         report_mismatch("responses outstanding", 0, expected_colours.size());

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
